### hw/rtl/isort_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isort_pkg: shared types and constants of the insertion sorter
// Data width, default store depth and the per-cycle control of the cells.
// ----------------------------------------------------------------------------
package isort_pkg;

  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  // Broadcast to every cell in the chain each cycle
  typedef struct packed {
    logic insert;  // place the new value, shift larger entries one cell up
    logic pop;     // shift every entry one cell down toward cell 0
  } cell_ctrl_t;

endpackage

### hw/rtl/insertion_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sorter: stable ascending sort of a stream of signed values
// A chain of DEPTH cells keeps the set sorted as it arrives; the last item
// of a set unloads the chain smallest first.
// ----------------------------------------------------------------------------
// Feed signed 32-bit values on the input channel, one transfer per cycle;
// each value drops into its place in a chain of DEPTH cells in the cycle it
// is taken, behind any equal entries, so the order is ascending and stable.
// A value that arrives while all DEPTH cells are full is dropped and the set
// is marked as overflowed. The transfer carrying last_item is inserted like
// any other, then the chain unloads: one result per stored entry, smallest
// first, one result per cycle while the output is not stalled, with
// last_result on the final one and overflowed on all of them. During the
// unload in_stall stays high, so the next set waits until the cell chain has
// shifted out every stored entry.
// After the final result the chain is empty and the next set may start.
// ----------------------------------------------------------------------------
module insertion_sorter import isort_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  data_t value,
  input  logic  last_item,
  output logic  out_valid,
  input  logic  out_stall,
  output data_t sorted_value,
  output logic  last_result,
  output logic  overflowed
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic             unloading;
  logic             overflow_seen;

  cell_ctrl_t ctrl;
  logic       in_xfer;
  logic       full;
  data_t      cell_value [DEPTH];
  logic       cell_gt    [DEPTH];

  // Hold the input off for the whole unload
  assign in_stall = unloading;
  assign in_xfer  = in_valid && !unloading;
  assign full     = count == CNT_W'(DEPTH);

  // Insert unless full; pop during an unload whenever the output register is free or draining
  assign ctrl.insert = in_xfer && !full;
  assign ctrl.pop    = unloading && (!out_valid || !out_stall);

  // Cell chain: neighbor i-1 feeds inserts, neighbor i+1 feeds pops
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    data_t prev_value;
    logic  prev_gt;
    data_t next_value;

    if (i == 0) begin : g_first
      assign prev_value = '0;
      assign prev_gt    = 1'b0;
    end else begin : g_mid
      assign prev_value = cell_value[i-1];
      assign prev_gt    = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_value = '0;
    end else begin : g_body
      assign next_value = cell_value[i+1];
    end

    isort_cell #(
      .DEPTH(DEPTH),
      .INDEX(i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count),
      .v         (value),
      .prev_value(prev_value),
      .prev_gt   (prev_gt),
      .next_value(next_value),
      .value     (cell_value[i]),
      .gt        (cell_gt[i])
    );
  end

  // Fill count, unload mode and the sticky drop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      unloading     <= 1'b0;
      overflow_seen <= 1'b0;
    end else begin
      if (ctrl.pop) begin
        count <= count - CNT_W'(1);
        // Leave unload mode on the final entry and start a fresh set
        if (count == CNT_W'(1)) begin
          unloading     <= 1'b0;
          overflow_seen <= 1'b0;
        end
      end else if (in_xfer) begin
        if (full) begin
          overflow_seen <= 1'b1;
        end else begin
          count <= count + CNT_W'(1);
        end
        if (last_item) begin
          unloading <= 1'b1;
        end
      end
    end
  end

  // Output register: load cell 0 on each pop, drop valid once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      sorted_value <= cell_value[0];
      last_result  <= count == CNT_W'(1);
      overflowed   <= overflow_seen;
    end
  end

endmodule

### hw/rtl/isort_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isort_cell: one slot of the sorting chain
// Holds one entry, compares it with the incoming value and trades entries
// with its neighbors on insert and pop.
// ----------------------------------------------------------------------------
module isort_cell import isort_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int INDEX = 0
) (
  input  logic                         clk,
  input  cell_ctrl_t                   ctrl,
  input  logic [$clog2(DEPTH+1)-1:0]   count,
  input  data_t                        v,
  input  data_t                        prev_value,
  input  logic                         prev_gt,
  input  data_t                        next_value,
  output data_t                        value,
  output logic                         gt
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic occupied;

  assign occupied = count > CNT_W'(INDEX);
  // An empty slot counts as greater, so the first empty slot takes the value
  assign gt = !occupied || (value > v);

  always_ff @(posedge clk) begin
    priority if (ctrl.pop) begin
      value <= next_value;
    end else if (ctrl.insert && prev_gt) begin
      value <= prev_value;
    end else if (ctrl.insert && gt) begin
      value <= v;
    end
  end

endmodule

### hw/rtl/isort_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isort_checker: port-level checks of the insertion sorter
// Watches the channels for ordering, set framing and output holding.
// ----------------------------------------------------------------------------
module isort_checker import isort_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  in_valid,
  input logic  in_stall,
  input data_t value,
  input logic  last_item,
  input logic  out_valid,
  input logic  out_stall,
  input data_t sorted_value,
  input logic  last_result,
  input logic  overflowed
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sorted_value)
      && $stable(last_result) && $stable(overflowed))
    else $error("stalled result changed");

  // Block the input after the last item of a set
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_item |=> in_stall)
    else $error("input taken right after last item");

  // Keep the input blocked in the middle of an unload
  a_unload_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_result |-> in_stall)
    else $error("input open during unload");

  // Advance in ascending order within a set
  a_ascending: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_result) ##1 out_valid
      |-> sorted_value >= $past(sorted_value))
    else $error("results out of order");

  // Carry one overflow flag across the whole set
  a_ovf_const: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_result) ##1 out_valid
      |-> overflowed == $past(overflowed))
    else $error("overflow flag changed within a set");

endmodule

bind insertion_sorter isort_checker u_isort_checker (.*);

### sim/insertion_sorter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sorter_test: self-checking bench for the insertion sorter
// Streams sets of signed values through the sorter, with random gaps on the
// input and random stalls on the output. A shadow sorted store predicts every
// result of every set. Each result is compared field by field in order.
// ----------------------------------------------------------------------------
module insertion_sorter_test;
  import isort_pkg::*;

  localparam int    DEPTH          = DEPTH_DEF;
  localparam data_t DATA_MIN       = {1'b1, {(DATA_W-1){1'b0}}};
  localparam data_t DATA_MAX       = {1'b0, {(DATA_W-1){1'b1}}};
  localparam int    RANDOM_ITEMS   = 80;
  localparam int    HOLD_CYCLES    = 300;   // long output hold for the pressure test
  localparam int    DRAIN_CYCLES   = 2 * DEPTH + 8;
  localparam int    WATCHDOG_LIMIT = 2000;  // well above the longest correct quiet spell
  localparam int    REPORT_LIMIT   = 10;

  // Receiver behavior for one stretch of cycles
  typedef enum int {RX_FLOW, RX_STALL, RX_CHOPPY, RX_HOLD} rx_mode_e;

  // One expected result of a set
  typedef struct {
    data_t sorted_value;
    logic  last_result;
    logic  overflowed;
  } sorted_entry_t;

  logic  clk          = 1'b0;
  logic  rst          = 1'b1;
  logic  in_valid     = 1'b0;
  logic  in_stall;
  data_t value        = '0;
  logic  last_item    = 1'b0;
  logic  out_valid;
  logic  out_stall    = 1'b0;
  data_t sorted_value;
  logic  last_result;
  logic  overflowed;

  // Shadow of the sorter: sorted entries of the open set and its drop flag
  data_t         shadow_store[$];
  bit            shadow_dropped;
  sorted_entry_t expected_sorted[$];
  sorted_entry_t want_entry;

  int  items_sent;
  int  sets_sent;
  int  dropped_sets;
  int  results_checked;
  int  mismatches;
  int  quiet_cycles;
  bit  no_input_gaps;
  bit  hold_request;
  bit  hold_active;

  insertion_sorter #(.DEPTH(DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .last_item    (last_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_value (sorted_value),
    .last_result  (last_result),
    .overflowed   (overflowed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Insert one accepted value behind any equal entries, or drop it when the
  // store is full. A last mark unloads the whole store as expected results.
  function automatic void predict_insert(data_t v, logic last);
    int pos;
    sorted_entry_t e;
    if (shadow_store.size() >= DEPTH) begin
      shadow_dropped = 1'b1;
    end else begin
      pos = 0;
      while (pos < shadow_store.size() && shadow_store[pos] <= v)
        pos++;
      shadow_store.insert(pos, v);
    end
    if (last) begin
      foreach (shadow_store[i]) begin
        e.sorted_value = shadow_store[i];
        e.last_result  = (i == shadow_store.size() - 1);
        e.overflowed   = shadow_dropped;
        expected_sorted.push_back(e);
      end
      sets_sent++;
      if (shadow_dropped)
        dropped_sets++;
      shadow_store.delete();
      shadow_dropped = 1'b0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Mostly back-to-back, sometimes a short pause, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6)
      return 0;
    else if (r < 9)
      return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // Full-range values mixed with tight ranges (lots of duplicates) and the
  // corners of the signed range
  function automatic data_t pick_value();
    case ($urandom_range(0, 5))
      0, 1:    return data_t'($urandom);
      2:       return data_t'(int'($urandom_range(0, 8)) - 4);
      3: begin
        case ($urandom_range(0, 5))
          0:       return DATA_MIN;
          1:       return DATA_MAX;
          2:       return data_t'(0);
          3:       return data_t'(-1);
          4:       return DATA_MIN + 1;
          default: return DATA_MAX - 1;
        endcase
      end
      4:       return data_t'($urandom_range(0, 15));
      default: return data_t'($urandom) >>> $urandom_range(0, 31);
    endcase
  endfunction

  // Offer one item and hold it until the sorter takes the transfer.
  // Called right after a rising edge, so every assignment lands on an edge.
  task automatic offer_value(data_t v, logic last);
    int gap;
    gap = no_input_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    value     <= v;
    last_item <= last;
    // in_stall is sampled as it stood just before the edge
    do @(posedge clk); while (in_stall);
    predict_insert(v, last);
    items_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Output side: stretches of free flow, choppy stalls, short and long holds,
  // plus one very long hold on request from the pressure test
  // --------------------------------------------------------------------------
  initial begin : out_stall_driver
    int       stretch;
    int       r;
    rx_mode_e mode;
    stretch = 0;
    mode    = RX_FLOW;
    forever begin
      @(posedge clk);
      if (stretch == 0) begin
        if (hold_request) begin
          hold_request = 1'b0;
          hold_active  = 1'b1;
          mode         = RX_HOLD;
          stretch      = HOLD_CYCLES;
        end else begin
          hold_active = 1'b0;
          r = $urandom_range(0, 9);
          if (r < 4) begin
            mode    = RX_FLOW;
            stretch = $urandom_range(1, 24);
          end else if (r < 7) begin
            mode    = RX_CHOPPY;
            stretch = $urandom_range(4, 16);
          end else if (r < 9) begin
            mode    = RX_STALL;
            stretch = $urandom_range(1, 3);
          end else begin
            mode    = RX_STALL;
            stretch = $urandom_range(10, 40);
          end
        end
      end
      stretch--;
      case (mode)
        RX_FLOW:   out_stall <= 1'b0;
        RX_CHOPPY: out_stall <= 1'($urandom_range(0, 1));
        default:   out_stall <= 1'b1;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result checking: every accepted result against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_sorted.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected result value %0d last %0b overflowed %0b",
                   $time, sorted_value, last_result, overflowed);
      end else begin
        want_entry = expected_sorted.pop_front();
        results_checked++;
        if (sorted_value !== want_entry.sorted_value ||
            last_result  !== want_entry.last_result  ||
            overflowed   !== want_entry.overflowed) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                     $time, want_entry.sorted_value, want_entry.last_result,
                     want_entry.overflowed, sorted_value, last_result, overflowed);
        end
      end
    end
  end

  // Count cycles in which neither side moves a transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    do @(posedge clk); while (quiet_cycles < WATCHDOG_LIMIT);
    $display("%0t: no transfer for %0d cycles, %0d results outstanding",
             $time, WATCHDOG_LIMIT, expected_sorted.size());
    $display("[insertion_sorter] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Sets of one entry, at both ends of the range
  task automatic test_single_entry();
    offer_value(DATA_MIN, 1'b1);
    offer_value(DATA_MAX, 1'b1);
  endtask

  // Signed corners in scrambled order; sign bit must order them correctly
  task automatic test_extreme_values();
    offer_value(DATA_MAX, 1'b0);
    offer_value(DATA_MIN, 1'b0);
    offer_value(data_t'(0), 1'b0);
    offer_value(data_t'(-1), 1'b0);
    offer_value(data_t'(1), 1'b0);
    offer_value(DATA_MIN + 1, 1'b0);
    offer_value(DATA_MAX - 1, 1'b0);
    offer_value(data_t'(32'h5555_AAAA), 1'b0);
    offer_value(data_t'(32'hAAAA_5555), 1'b1);
  endtask

  // Runs of equal values interleaved with others
  task automatic test_equal_runs();
    offer_value(data_t'(5), 1'b0);
    offer_value(data_t'(5), 1'b0);
    offer_value(data_t'(-3), 1'b0);
    offer_value(data_t'(5), 1'b0);
    offer_value(data_t'(-3), 1'b0);
    offer_value(data_t'(7), 1'b0);
    offer_value(data_t'(5), 1'b1);
  endtask

  // Exactly full, then full with the last item dropped, then drops before
  // the last item
  task automatic test_full_store();
    no_input_gaps = 1'b1;
    for (int i = 0; i < DEPTH; i++)
      offer_value(data_t'(1000 - 37 * i), i == DEPTH - 1);
    no_input_gaps = 1'b0;
    for (int i = 0; i <= DEPTH; i++)
      offer_value(pick_value(), i == DEPTH);
    for (int i = 0; i < DEPTH + 3; i++)
      offer_value(pick_value(), i == DEPTH + 2);
  endtask

  // Hold the output off for a long time while a full set and the next set
  // are offered back to back; the unload backs up into the input
  task automatic test_output_backpressure();
    // Withdraw the previous item while waiting for the hold to start
    in_valid <= 1'b0;
    hold_request = 1'b1;
    while (!hold_active) @(posedge clk);
    no_input_gaps = 1'b1;
    for (int i = 0; i < DEPTH + 8; i++)
      offer_value(pick_value(), i == DEPTH + 7);
    for (int i = 0; i < 10; i++)
      offer_value(pick_value(), i == 9);
    no_input_gaps = 1'b0;
  endtask

  // Well-formed sets of random size and content; mostly small sets, some
  // close to or over the store size
  task automatic test_random_sets();
    int sent;
    int set_len;
    int r;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r < 7)
        set_len = $urandom_range(1, 8);
      else if (r < 9)
        set_len = $urandom_range(9, DEPTH - 1);
      else
        set_len = $urandom_range(DEPTH, DEPTH + 4);
      no_input_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < set_len; i++)
        offer_value(pick_value(), i == set_len - 1);
      sent += set_len;
    end
    no_input_gaps = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : main
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_entry();
    test_extreme_values();
    test_equal_runs();
    test_full_store();
    test_output_backpressure();
    test_random_sets();

    // Drop valid, drain what is still owed, then watch for strays
    in_valid <= 1'b0;
    while (expected_sorted.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sorted %0d sets from %0d input transfers, %0d with dropped values;",
             sets_sent, items_sent, dropped_sets);
    $display("checked %0d results, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0 && expected_sorted.size() == 0)
      $display("[insertion_sorter] OK");
    else
      $display("[insertion_sorter] ERROR");
    $finish;
  end

endmodule

### files.f
hw/rtl/isort_pkg.sv
hw/rtl/isort_cell.sv
hw/rtl/insertion_sorter.sv
hw/rtl/isort_checker.sv
sim/insertion_sorter_test.sv
